FILE: hw/rtl/rsi_pkg.sv
// ----------------------------------------------------------------------------
// rsi_pkg: ray-sphere intersection shared definitions
// Widths, register indexes and the structs handed along the cell chains.
// ----------------------------------------------------------------------------
package rsi_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;
    localparam int RAD_W     = WORD_BITS - 1;
    localparam int IN_DATA_W = 6 * WORD_BITS;
    localparam int OC_W      = WORD_BITS + 1;      // origin - center
    localparam int A_W       = 2 * WORD_BITS;      // a = d.d
    localparam int HM_W      = 2 * WORD_BITS + 1;  // |h|
    localparam int CM_W      = 2 * WORD_BITS + 2;  // |c|
    localparam int DISC_W    = 4 * WORD_BITS + 4;  // discriminant
    localparam int ROOT_W    = DISC_W / 2;         // integer square root
    localparam int SQ_REM_W  = ROOT_W + 2;
    localparam int NUM_W     = ROOT_W + 1;         // |-h - s|
    localparam int NUM16_W   = NUM_W + FRAC_BITS;
    localparam int Q_W       = WORD_BITS + 1;      // quotient bits kept
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS   = 2'd3;

    typedef struct packed {
        logic            valid;
        logic            miss;
        logic            hneg;
        logic [HM_W-1:0] hm;
        logic [A_W-1:0]  a;
    } sq_side_t;

    typedef struct packed {
        logic [DISC_W-1:0]   x;
        logic [SQ_REM_W-1:0] rem;
        logic [ROOT_W-1:0]   root;
    } sq_data_t;

    typedef struct packed {
        logic           valid;
        logic           miss;
        logic           nneg;
        logic           ovf;
        logic [A_W-1:0] a;
    } dv_side_t;

    typedef struct packed {
        logic [Q_W-1:0] n;
        logic [A_W-1:0] rem;
        logic [Q_W-1:0] q;
    } dv_data_t;

endpackage

FILE: hw/rtl/ray_sphere_intersection.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection: ray against a configured sphere
// Nearer-root intersection, one ray per cycle when not stalled, Q16.16 fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one ray per transfer, origin xyz then direction xyz.
//   m_ channel: one result per ray, in order; m_tuser = hit, m_tdata = t
//   (saturated Q16.16, zero on a miss).
//   cfg port: center x/y/z and radius, written while no ray is in flight.
// Pipeline: 7 setup stages, 66 square-root cells (one root bit each),
//   1 numerator stage, 33 divider cells (one quotient bit each),
//   1 output register.
// Throughput: one ray per cycle when not stalled; the square-root and divider
//   cell chains pass data to the next cell every cycle that the pipeline advances.
// Reset: clears all valid flags, center to 0 and radius to 1.0.
// Stall: while m_tvalid is high and m_tready low the whole pipeline holds
//   and s_tready is low; the result register stays stable.
// ----------------------------------------------------------------------------
module ray_sphere_intersection (
    input  logic                              aclk,
    input  logic                              aresetn,
    // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z (32 bits each)
    input  logic [rsi_pkg::IN_DATA_W-1:0]     s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // hit_t
    output logic [rsi_pkg::WORD_BITS-1:0]     m_tdata,
    // hit
    output logic                              m_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_wr_en,
    input  logic [rsi_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rsi_pkg::WORD_BITS-1:0]     cfg_wdata
);

    localparam int W  = rsi_pkg::WORD_BITS;
    localparam int QW = rsi_pkg::Q_W;
    localparam int NR = rsi_pkg::ROOT_W;

    logic signed [W-1:0]         center_x_reg, center_y_reg, center_z_reg;
    logic [rsi_pkg::RAD_W-1:0]   radius_reg;
    logic                        adv;
    logic                        m_tvalid_reg;
    logic [W-1:0]                m_tdata_reg;
    logic                        m_tuser_reg;
    logic [W-1:0]                t_next;
    logic [QW-1:0]               lim;
    logic [QW-1:0]               qv;

    rsi_pkg::sq_side_t sq_side [NR+1];
    rsi_pkg::sq_data_t sq_data [NR+1];
    rsi_pkg::dv_side_t dv_side [QW+1];
    rsi_pkg::dv_data_t dv_data [QW+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            radius_reg   <= rsi_pkg::RAD_W'(1) << rsi_pkg::FRAC_BITS;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                rsi_pkg::REG_CENTER_X: center_x_reg <= cfg_wdata;
                rsi_pkg::REG_CENTER_Y: center_y_reg <= cfg_wdata;
                rsi_pkg::REG_CENTER_Z: center_z_reg <= cfg_wdata;
                rsi_pkg::REG_RADIUS:   radius_reg   <= cfg_wdata[rsi_pkg::RAD_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    rsi_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .in_valid (s_tvalid),
        .in_data  (s_tdata),
        .center_x (center_x_reg),
        .center_y (center_y_reg),
        .center_z (center_z_reg),
        .radius   (radius_reg),
        .side_out (sq_side[0]),
        .data_out (sq_data[0])
    );

    for (genvar g = 0; g < NR; g++) begin : g_sqrt
        rsi_sqrt_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .side_in  (sq_side[g]),
            .data_in  (sq_data[g]),
            .side_out (sq_side[g+1]),
            .data_out (sq_data[g+1])
        );
    end

    rsi_setup u_setup (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (adv),
        .side_in  (sq_side[NR]),
        .data_in  (sq_data[NR]),
        .side_out (dv_side[0]),
        .data_out (dv_data[0])
    );

    for (genvar g = 0; g < QW; g++) begin : g_div
        rsi_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .side_in  (dv_side[g]),
            .data_in  (dv_data[g]),
            .side_out (dv_side[g+1]),
            .data_out (dv_data[g+1])
        );
    end

    // saturate to the signed word range
    always_comb begin
        lim = dv_side[QW].nneg ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - QW'(1));
        qv  = (dv_side[QW].ovf || (dv_data[QW].q > lim)) ? lim : dv_data[QW].q;
        if (dv_side[QW].miss) begin
            t_next = '0;
        end else if (dv_side[QW].nneg) begin
            t_next = W'(QW'(0) - qv);
        end else begin
            t_next = W'(qv);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_side[QW].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= t_next;
            m_tuser_reg <= !dv_side[QW].miss;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

FILE: hw/rtl/rsi_front.sv
// ----------------------------------------------------------------------------
// rsi_front: quadratic setup pipeline
// Forms oc, a, h, c and the discriminant over seven registered stages.
// ----------------------------------------------------------------------------
module rsi_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                adv,
    input  logic                                in_valid,
    input  logic [rsi_pkg::IN_DATA_W-1:0]       in_data,
    input  logic signed [rsi_pkg::WORD_BITS-1:0] center_x,
    input  logic signed [rsi_pkg::WORD_BITS-1:0] center_y,
    input  logic signed [rsi_pkg::WORD_BITS-1:0] center_z,
    input  logic [rsi_pkg::RAD_W-1:0]           radius,
    output rsi_pkg::sq_side_t                   side_out,
    output rsi_pkg::sq_data_t                   data_out
);

    localparam int W  = rsi_pkg::WORD_BITS;
    localparam int HL = W + 1;

    logic signed [W-1:0] org [3];
    logic signed [W-1:0] dir [3];
    logic signed [W-1:0] cen [3];

    logic [5:0] v_reg;
    logic       v7_reg;

    logic signed [rsi_pkg::OC_W-1:0] oc1_reg [3];
    logic signed [W-1:0]             d1_reg  [3];
    logic [2*W-1:0]                  dd2_reg [3];
    logic signed [2*W:0]             doc2_reg [3];
    logic [2*W+1:0]                  oo2_reg [3];
    logic [2*rsi_pkg::RAD_W-1:0]     rr2_reg;
    logic [rsi_pkg::A_W-1:0]         a3_reg;
    logic signed [rsi_pkg::HM_W:0]   h3_reg;
    logic signed [rsi_pkg::CM_W:0]   c3_reg;
    logic [rsi_pkg::HM_W-1:0]        hm4_reg, hm5_reg, hm6_reg;
    logic [rsi_pkg::CM_W-1:0]        cm4_reg;
    logic [rsi_pkg::A_W-1:0]         a4_reg, a5_reg, a6_reg;
    logic                            hneg4_reg, hneg5_reg, hneg6_reg;
    logic                            cneg4_reg, cneg5_reg, cneg6_reg;
    logic                            zero4_reg, zero5_reg, zero6_reg;
    logic [2*HL-1:0]                 p_hll_reg;
    logic [2*HL-2:0]                 p_hlh_reg;
    logic [2*W-1:0]                  p_hhh_reg;
    logic [2*W:0]                    p_ll_reg, p_lh_reg, p_hl_reg, p_hh_reg;
    logic [rsi_pkg::DISC_W-1:0]      h2_6_reg, ac6_reg;
    rsi_pkg::sq_side_t               side_reg;
    rsi_pkg::sq_data_t               data_reg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            org[i] = in_data[i*W +: W];
            dir[i] = in_data[(i+3)*W +: W];
        end
        cen[0] = center_x;
        cen[1] = center_y;
        cen[2] = center_z;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg  <= '0;
            v7_reg <= 1'b0;
        end else if (adv) begin
            v_reg  <= {v_reg[4:0], in_valid};
            v7_reg <= v_reg[5];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 3; i++) begin
                oc1_reg[i]  <= rsi_pkg::OC_W'(org[i]) - rsi_pkg::OC_W'(cen[i]);
                d1_reg[i]   <= dir[i];
                dd2_reg[i]  <= (2*W)'((2*W)'(d1_reg[i]) * (2*W)'(d1_reg[i]));
                doc2_reg[i] <= (2*W+1)'(d1_reg[i]) * (2*W+1)'(oc1_reg[i]);
                oo2_reg[i]  <= (2*W+2)'((2*W+2)'(oc1_reg[i]) * (2*W+2)'(oc1_reg[i]));
            end
            rr2_reg <= (2*rsi_pkg::RAD_W)'(radius) * (2*rsi_pkg::RAD_W)'(radius);

            a3_reg <= dd2_reg[0] + dd2_reg[1] + dd2_reg[2];
            h3_reg <= (rsi_pkg::HM_W+1)'(doc2_reg[0]) + (rsi_pkg::HM_W+1)'(doc2_reg[1])
                    + (rsi_pkg::HM_W+1)'(doc2_reg[2]);
            c3_reg <= (rsi_pkg::CM_W+1)'(oo2_reg[0]) + (rsi_pkg::CM_W+1)'(oo2_reg[1])
                    + (rsi_pkg::CM_W+1)'(oo2_reg[2]) - (rsi_pkg::CM_W+1)'(rr2_reg);

            hneg4_reg <= h3_reg[rsi_pkg::HM_W];
            hm4_reg   <= h3_reg[rsi_pkg::HM_W] ? rsi_pkg::HM_W'(-h3_reg)
                                               : rsi_pkg::HM_W'(h3_reg);
            cneg4_reg <= c3_reg[rsi_pkg::CM_W];
            cm4_reg   <= c3_reg[rsi_pkg::CM_W] ? rsi_pkg::CM_W'(-c3_reg)
                                               : rsi_pkg::CM_W'(c3_reg);
            a4_reg    <= a3_reg;
            zero4_reg <= (a3_reg == '0);

            p_hll_reg <= (2*HL)'(hm4_reg[HL-1:0]) * (2*HL)'(hm4_reg[HL-1:0]);
            p_hlh_reg <= (2*HL-1)'(hm4_reg[HL-1:0]) * (2*HL-1)'(hm4_reg[2*W:HL]);
            p_hhh_reg <= (2*W)'(hm4_reg[2*W:HL]) * (2*W)'(hm4_reg[2*W:HL]);
            p_ll_reg  <= (2*W+1)'(a4_reg[W-1:0]) * (2*W+1)'(cm4_reg[HL-1:0]);
            p_lh_reg  <= (2*W+1)'(a4_reg[W-1:0]) * (2*W+1)'(cm4_reg[2*W+1:HL]);
            p_hl_reg  <= (2*W+1)'(a4_reg[2*W-1:W]) * (2*W+1)'(cm4_reg[HL-1:0]);
            p_hh_reg  <= (2*W+1)'(a4_reg[2*W-1:W]) * (2*W+1)'(cm4_reg[2*W+1:HL]);
            hm5_reg   <= hm4_reg;
            hneg5_reg <= hneg4_reg;
            a5_reg    <= a4_reg;
            cneg5_reg <= cneg4_reg;
            zero5_reg <= zero4_reg;

            h2_6_reg  <= (rsi_pkg::DISC_W'(p_hhh_reg) << (2*HL))
                       + (rsi_pkg::DISC_W'(p_hlh_reg) << (HL+1))
                       + rsi_pkg::DISC_W'(p_hll_reg);
            ac6_reg   <= (rsi_pkg::DISC_W'(p_hh_reg) << (W+HL))
                       + (rsi_pkg::DISC_W'(p_lh_reg) << HL)
                       + (rsi_pkg::DISC_W'(p_hl_reg) << W)
                       + rsi_pkg::DISC_W'(p_ll_reg);
            hm6_reg   <= hm5_reg;
            hneg6_reg <= hneg5_reg;
            a6_reg    <= a5_reg;
            cneg6_reg <= cneg5_reg;
            zero6_reg <= zero5_reg;

            side_reg.valid <= v_reg[5];
            side_reg.miss  <= zero6_reg || (!cneg6_reg && (h2_6_reg < ac6_reg));
            side_reg.hneg  <= hneg6_reg;
            side_reg.hm    <= hm6_reg;
            side_reg.a     <= a6_reg;
            data_reg.x     <= cneg6_reg ? h2_6_reg + ac6_reg : h2_6_reg - ac6_reg;
            data_reg.rem   <= '0;
            data_reg.root  <= '0;
        end
    end

    always_comb begin
        side_out       = side_reg;
        side_out.valid = v7_reg;
        data_out       = data_reg;
    end

endmodule

FILE: hw/rtl/rsi_sqrt_cell.sv
// ----------------------------------------------------------------------------
// rsi_sqrt_cell: one root bit of the integer square root
// Takes two radicand bits, decides one root bit, hands on to the next cell.
// ----------------------------------------------------------------------------
module rsi_sqrt_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  rsi_pkg::sq_side_t side_in,
    input  rsi_pkg::sq_data_t data_in,
    output rsi_pkg::sq_side_t side_out,
    output rsi_pkg::sq_data_t data_out
);

    localparam int RW = rsi_pkg::SQ_REM_W;
    localparam int DW = rsi_pkg::DISC_W;

    logic [RW+1:0]     r4;
    logic [RW+1:0]     trial;
    logic              ge;
    rsi_pkg::sq_data_t data_next;
    rsi_pkg::sq_data_t data_reg;
    rsi_pkg::sq_side_t side_reg;
    logic              valid_reg;

    always_comb begin
        r4             = {data_in.rem, data_in.x[DW-1:DW-2]};
        trial          = (RW+2)'({data_in.root, 2'b01});
        ge             = (r4 >= trial);
        data_next.x    = data_in.x << 2;
        data_next.rem  = ge ? RW'(r4 - trial) : RW'(r4);
        data_next.root = {data_in.root[rsi_pkg::ROOT_W-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= side_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= side_in;
            data_reg <= data_next;
        end
    end

    always_comb begin
        side_out       = side_reg;
        side_out.valid = valid_reg;
        data_out       = data_reg;
    end

endmodule

FILE: hw/rtl/rsi_setup.sv
// ----------------------------------------------------------------------------
// rsi_setup: numerator and divider load
// Forms -h - sqrt(disc), scales it, flags quotient overflow, loads the divider.
// ----------------------------------------------------------------------------
module rsi_setup (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  rsi_pkg::sq_side_t side_in,
    input  rsi_pkg::sq_data_t data_in,
    output rsi_pkg::dv_side_t side_out,
    output rsi_pkg::dv_data_t data_out
);

    localparam int NW = rsi_pkg::NUM_W;
    localparam int SW = rsi_pkg::NUM16_W;
    localparam int QW = rsi_pkg::Q_W;

    logic [NW-1:0]     hm_x;
    logic [NW-1:0]     s_x;
    logic [NW-1:0]     num;
    logic              nneg;
    logic [SW-1:0]     num16;
    logic [SW-QW-1:0]  top_part;
    rsi_pkg::dv_side_t side_reg;
    rsi_pkg::dv_data_t data_reg;
    logic              valid_reg;

    always_comb begin
        hm_x = NW'(side_in.hm);
        s_x  = NW'(data_in.root);
        if (!side_in.hneg) begin
            num  = hm_x + s_x;
            nneg = 1'b1;
        end else if (hm_x >= s_x) begin
            num  = hm_x - s_x;
            nneg = 1'b0;
        end else begin
            num  = s_x - hm_x;
            nneg = 1'b1;
        end
        num16    = {num, {rsi_pkg::FRAC_BITS{1'b0}}};
        top_part = num16[SW-1:QW];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= side_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg.valid <= side_in.valid;
            side_reg.miss  <= side_in.miss;
            side_reg.nneg  <= nneg;
            side_reg.ovf   <= (rsi_pkg::A_W'(top_part) >= side_in.a);
            side_reg.a     <= side_in.a;
            data_reg.n     <= num16[QW-1:0];
            data_reg.rem   <= rsi_pkg::A_W'(top_part);
            data_reg.q     <= '0;
        end
    end

    always_comb begin
        side_out       = side_reg;
        side_out.valid = valid_reg;
        data_out       = data_reg;
    end

endmodule

FILE: hw/rtl/rsi_div_cell.sv
// ----------------------------------------------------------------------------
// rsi_div_cell: one quotient bit of the restoring divider
// Shifts in one numerator bit, trial-subtracts a, hands on to the next cell.
// ----------------------------------------------------------------------------
module rsi_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  rsi_pkg::dv_side_t side_in,
    input  rsi_pkg::dv_data_t data_in,
    output rsi_pkg::dv_side_t side_out,
    output rsi_pkg::dv_data_t data_out
);

    localparam int AW = rsi_pkg::A_W;
    localparam int QW = rsi_pkg::Q_W;

    logic [AW:0]       r2;
    logic [AW:0]       den;
    logic              ge;
    rsi_pkg::dv_data_t data_next;
    rsi_pkg::dv_data_t data_reg;
    rsi_pkg::dv_side_t side_reg;
    logic              valid_reg;

    always_comb begin
        r2          = {data_in.rem, data_in.n[QW-1]};
        den         = {1'b0, side_in.a};
        ge          = (r2 >= den);
        data_next.n   = data_in.n << 1;
        data_next.rem = ge ? AW'(r2 - den) : AW'(r2);
        data_next.q   = {data_in.q[QW-2:0], ge};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= side_in.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg <= side_in;
            data_reg <= data_next;
        end
    end

    always_comb begin
        side_out       = side_reg;
        side_out.valid = valid_reg;
        data_out       = data_reg;
    end

endmodule

FILE: hw/rtl/rsi_checker.sv
// ----------------------------------------------------------------------------
// rsi_checker: port-level checks for ray_sphere_intersection
// Watches the stream ports; bound to the top level below.
// ----------------------------------------------------------------------------
module rsi_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tready,
    input logic [rsi_pkg::WORD_BITS-1:0] m_tdata,
    input logic                          m_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a miss reports t = 0
    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("miss with nonzero t");

    // a stalled output backs up the input side
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while output stalled");

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule

bind ray_sphere_intersection rsi_checker u_rsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready)
);

FILE: tb/ray_sphere_intersection_tb.sv
// ----------------------------------------------------------------------------
// ray_sphere_intersection_tb: self-checking bench for the ray/sphere unit
// Streams rays through the block, predicts hit and nearer-root t with wide
// exact integer math, and checks every result in order under random stalls.
// ----------------------------------------------------------------------------
module ray_sphere_intersection_tb;
    import rsi_pkg::*;

    localparam int  LATENCY   = 108;
    localparam int  MAX_CYC   = 1500000;
    localparam logic [31:0] ONE  = 32'h0001_0000;
    localparam logic [31:0] SMAX = 32'h7fff_ffff;
    localparam logic [31:0] SMIN = 32'h8000_0000;

    typedef struct packed {
        logic        hit;
        logic [31:0] t;
    } hit_res_t;

    logic                   aclk = 0;
    logic                   aresetn = 0;
    logic [IN_DATA_W-1:0]   s_tdata = '0;
    logic                   s_tvalid = 0;
    logic                   s_tready;
    logic [WORD_BITS-1:0]   m_tdata;
    logic                   m_tuser;
    logic                   m_tvalid;
    logic                   m_tready = 0;
    logic                   cfg_wr_en = 0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [WORD_BITS-1:0]   cfg_wdata = '0;

    logic [31:0] ctr [3];
    logic [30:0] rad;
    hit_res_t    hits_pending [$];
    int          errors = 0, rays_sent = 0, results_seen = 0, hits_seen = 0;
    int          cycles = 0;
    int          send_idle = 0, recv_stall = 0;

    ray_sphere_intersection dut (.*);

    always begin
        #6 aclk = 1;
        #6 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > MAX_CYC) begin
            $display("timeout after %0d cycles", cycles);
            $display("ray_sphere_intersection test failed");
            $finish;
        end
    end

    always @(negedge aclk)
        m_tready <= ($urandom_range(99) >= recv_stall);

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40) $display("MISMATCH @%0d: %s", cycles, msg);
    endtask

    always @(posedge aclk) begin
        hit_res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (m_tuser) hits_seen++;
            if (hits_pending.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = hits_pending.pop_front();
                if (m_tuser !== want.hit)
                    report_mismatch($sformatf("hit got %b want %b", m_tuser, want.hit));
                if (m_tdata !== want.t)
                    report_mismatch($sformatf("t got %h want %h", m_tdata, want.t));
            end
        end
    end

    function automatic hit_res_t predict_hit(input logic [IN_DATA_W-1:0] ray);
        logic signed [263:0] d, oc, a, h, c, r, disc, s, cand, num, q;
        hit_res_t res;
        a = 0; h = 0; c = 0;
        res = '0;
        for (int i = 0; i < 3; i++) begin
            d  = $signed(ray[96+32*i +: 32]);
            oc = $signed(ray[32*i +: 32]);
            oc = oc - $signed(ctr[i]);
            a  = a + d * d;
            h  = h + oc * d;
            c  = c + oc * oc;
        end
        r = {233'b0, rad};
        c = c - r * r;
        if (a == 0) return res;
        disc = h * h - a * c;
        if (disc < 0) return res;
        s = 0;
        for (int k = 67; k >= 0; k--) begin
            cand = s | (264'sd1 <<< k);
            if (cand * cand <= disc) s = cand;
        end
        num = -h - s;
        q = (num <<< FRAC_BITS) / a;
        res.hit = 1;
        if (q > $signed({232'b0, SMAX})) res.t = SMAX;
        else if (q < -$signed({232'b0, SMIN})) res.t = SMIN;
        else res.t = q[31:0];
        return res;
    endfunction

    task automatic send_ray(input logic [31:0] ox, oy, oz, dx, dy, dz);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tdata  = {dz, dy, dx, oz, oy, ox};
        s_tvalid = 1;
        do @(posedge aclk); while (!s_tready);
        hits_pending.push_back(predict_hit(s_tdata));
        rays_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_tvalid = 0;
        while (hits_pending.size() != 0) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en = 1; cfg_index = idx; cfg_wdata = val;
        case (idx)
            REG_CENTER_X: ctr[0] = val;
            REG_CENTER_Y: ctr[1] = val;
            REG_CENTER_Z: ctr[2] = val;
            REG_RADIUS:   rad = val[30:0];
        endcase
        @(negedge aclk);
        cfg_wr_en = 0;
    endtask

    task automatic set_sphere(input logic [31:0] cx, cy, cz, rr);
        drain();
        write_reg(REG_CENTER_X, cx);
        write_reg(REG_CENTER_Y, cy);
        write_reg(REG_CENTER_Z, cz);
        write_reg(REG_RADIUS, rr);
    endtask

    // unit sphere at the origin
    task automatic test_directed();
        send_ray(0, 0, -5*ONE, 0, 0, 0);                    // zero direction
        send_ray(0, ONE, -5*ONE, 0, 0, ONE);                 // tangent
        send_ray(0, 2*ONE, -5*ONE, 0, 0, ONE);               // miss
        send_ray(0, 0, -5*ONE, 0, 0, ONE);                   // front hit
        send_ray(0, 0, 5*ONE, 0, 0, ONE);                    // sphere behind
        send_ray(0, 0, 0, ONE, 0, 0);                        // origin inside
        send_ray(0, 0, SMIN, 0, 0, 1);                       // t saturates high
        send_ray(0, 0, SMAX, 0, 0, 1);                       // t saturates low
        send_ray(SMAX, SMAX, SMAX, SMIN, SMIN, SMIN);
        send_ray(SMIN, SMIN, SMIN, SMAX, SMAX, SMAX);
        send_ray(SMIN, SMAX, 0, SMIN, SMAX, 1);
        send_ray(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 1, 1, 1);
        send_ray(0, 0, -3*ONE, 0, 0, SMIN);
        send_ray(0, 0, 3*ONE, 0, 0, SMIN);
        send_ray(ONE/2, ONE/2, -4*ONE, 0, 0, ONE*3);
    endtask

    task automatic send_random_ray();
        logic [31:0] o [3], d [3];
        int pick = $urandom_range(99);
        for (int i = 0; i < 3; i++) begin
            if (pick < 65) begin
                // aimed near the center from a modest distance
                o[i] = ctr[i] + $signed($urandom_range(0, 32*ONE)) - 16*ONE;
                d[i] = ctr[i] - o[i] + $signed($urandom_range(0, 2*ONE)) - ONE;
                if (pick < 10) d[i] = d[i] >>> $urandom_range(0, 20);
            end else if (pick < 85) begin
                o[i] = $urandom;
                d[i] = $urandom;
            end else begin
                o[i] = $signed($urandom_range(0, 64*ONE)) - 32*ONE;
                d[i] = (pick < 88) ? 0 : $signed($urandom_range(0, 8*ONE)) - 4*ONE;
            end
        end
        send_ray(o[0], o[1], o[2], d[0], d[1], d[2]);
    endtask

    task automatic test_random(input int n, input int idle, input int stall);
        send_idle = idle; recv_stall = stall;
        repeat (n) send_random_ray();
    endtask

    task automatic test_pause_until_empty();
        repeat (10) send_random_ray();
        @(negedge aclk);
        s_tvalid = 0;
        while (hits_pending.size() != 0) @(posedge aclk);
        repeat (10) send_random_ray();
    endtask

    initial begin
        ctr[0] = 0; ctr[1] = 0; ctr[2] = 0; rad = ONE[30:0];
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        test_directed();
        test_random(100, 0, 0);
        set_sphere(3*ONE, -2*ONE, 10*ONE, 4*ONE);
        test_random(100, 73, 0);
        test_pause_until_empty();
        set_sphere(SMAX, SMIN, SMAX, 0);
        test_random(80, 0, 73);
        set_sphere(SMIN, SMAX, SMIN, SMAX);
        test_random(80, 15, 15);
        set_sphere($urandom, $urandom, $urandom, $urandom);
        test_random(100, 73, 73);
        set_sphere(-7*ONE, 5*ONE, 0, ONE/3);
        test_random(100, 15, 15);
        test_random(100, 0, 0);
        drain();

        $display("rays sent %0d, results checked %0d (%0d hits) over six sphere settings",
                 rays_sent, results_seen, hits_seen);
        $display("idle/stall phases, extreme centers and radii, zero and tiny directions");
        if (errors == 0 && hits_pending.size() == 0)
            $display("ray_sphere_intersection test passed");
        else begin
            $display("%0d mismatches, %0d results missing", errors, hits_pending.size());
            $display("ray_sphere_intersection test failed");
        end
        $finish;
    end
endmodule
